// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/nlsr_pkg.sv =====
// Package with shared types and constants of the logarithm unit.
package nlsr_pkg;
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_RANGE  = 2'd1;
    localparam logic [1:0] STATUS_DOMAIN = 2'd2;

    typedef enum logic [1:0] {
        OP_SQRT = 2'd0,
        OP_DIV  = 2'd1
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture operand and set up x and r
        logic start;      // start one iterative operation
        op_t  op;         // which operation
        logic finish;     // round r and fill the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;       // iterative unit is running
        logic converged;  // |x - 1| within tolerance
    } dp_sts_t;
endpackage

// ===== hdl/natural_log_by_square_roots_unit.sv =====
// Top level of the natural logarithm unit by repeated square roots.
// Each word runs up to MAX_ROUNDS rounds before its result is rounded.
// Each round runs one bit-serial root (FB+16 steps) then one divide (2*(FB+16) steps).
// The single shared root/divide unit sets the time; one word is in work at a time.
// Zero and negative operands pass through S_SPEC to S_OUT and skip the rounds.
// Reset (aresetn, synchronous, low) returns to idle and sets tolerance to 1.
module natural_log_by_square_roots_unit #(
    parameter int MAX_ROUNDS = 64,
    parameter int INTERNAL_FRACTION_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_operand,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_log_value,
    output logic [1:0]  m_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);
    nlsr_pkg::dp_cmd_t cmd;
    nlsr_pkg::dp_sts_t sts;
    logic [16:0] tol_reg;
    logic [31:0] op_reg;
    logic [31:0] raw_log;

    // The tolerance register takes a word whenever one is offered.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) tol_reg <= 17'd1;
        else if (cfg_valid) tol_reg <= cfg_data;
    end

    // The operand is captured on every accepted word, alongside any load command.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) op_reg <= s_operand;
    end

    nlsr_ctrl #(.MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_operand,
        .m_valid, .m_ready, .m_status, .cmd, .sts
    );

    nlsr_datapath #(.FB(INTERNAL_FRACTION_BITS)) u_dp (
        .aclk, .aresetn, .operand(s_operand), .tolerance(tol_reg),
        .cmd, .sts, .log_value(raw_log)
    );

    // Special cases, and an operand of exactly one, override the rounded value.
    always_comb begin
        unique case (m_status)
            nlsr_pkg::STATUS_RANGE:  m_log_value = 32'h80000000;
            nlsr_pkg::STATUS_DOMAIN: m_log_value = 32'd0;
            default:                 m_log_value = (op_reg == 32'h00010000) ? 32'd0 : raw_log;
        endcase
    end
endmodule

// ===== hdl/nlsr_datapath.sv =====
// Datapath: x and r registers, shared bit-serial root/divide unit, result rounding.
module nlsr_datapath #(
    parameter int FB = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [31:0]         operand,
    input  logic [16:0]         tolerance,
    input  nlsr_pkg::dp_cmd_t   cmd,
    output nlsr_pkg::dp_sts_t   sts,
    output logic [31:0]         log_value
);
    localparam int W   = FB + 16;          // width of x and |r|
    localparam int CW  = $clog2(2 * W + 1);
    localparam logic [W-1:0] ONE = W'(1) << FB;

    logic [W-1:0]   x_reg, x_next;
    logic [W-1:0]   mag_reg, mag_next;
    logic           neg_reg, neg_next;
    logic [2*W-1:0] num_reg, num_next;     // operand bits, consumed from the top
    logic [W+1:0]   rem_reg, rem_next;
    logic [W-1:0]   q_reg, q_next;
    logic [W-1:0]   den_reg, den_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    nlsr_pkg::op_t  op_reg, op_next;
    logic [31:0]    out_reg, out_next;

    logic [W-1:0]   x_init, dev, tol_w;
    logic [W+1:0]   rem_sh, trial;
    logic [W-1:0]   rnd;
    logic [W+1:0]   wide_tol;

    always_comb begin
        x_init = W'(operand) << (FB - 16);
        dev = (x_reg >= ONE) ? x_reg - ONE : ONE - x_reg;
        wide_tol = (W + 2)'(tolerance);
        if (FB >= 32) tol_w = W'(wide_tol << (FB - 32));
        else tol_w = W'(wide_tol >> (32 - FB));
        sts.converged = dev <= tol_w;
        sts.busy = busy_reg;
    end

    always_comb begin
        x_next = x_reg; mag_next = mag_reg; neg_next = neg_reg;
        num_next = num_reg; rem_next = rem_reg; q_next = q_reg;
        den_next = den_reg; cnt_next = cnt_reg; busy_next = busy_reg;
        op_next = op_reg; out_next = out_reg;
        rem_sh = '0; trial = '0; rnd = '0;
        if (cmd.load) begin
            x_next = x_init;
            neg_next = x_init < ONE;
            mag_next = (x_init < ONE) ? ONE - x_init : x_init - ONE;
        end
        if (cmd.start) begin
            busy_next = 1'b1;
            op_next = cmd.op;
            rem_next = '0;
            q_next = '0;
            unique case (cmd.op)
                nlsr_pkg::OP_SQRT: begin
                    num_next = (2*W)'(x_reg) << FB;
                    cnt_next = CW'(W);
                end
                nlsr_pkg::OP_DIV: begin
                    num_next = (2*W)'(mag_reg) << (FB + 1);
                    den_next = ONE + x_reg;
                    cnt_next = CW'(2 * W);
                end
                default: ;
            endcase
        end else if (busy_reg) begin
            if (op_reg == nlsr_pkg::OP_SQRT) begin
                rem_sh = {rem_reg[W-1:0], num_reg[2*W-1 -: 2]};
                trial = {q_reg, 2'b01};
                num_next = num_reg << 2;
                if (rem_sh >= trial) begin
                    rem_next = rem_sh - trial;
                    q_next = {q_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next = {q_reg[W-2:0], 1'b0};
                end
            end else begin
                rem_sh = {rem_reg[W:0], num_reg[2*W-1]};
                num_next = num_reg << 1;
                if (rem_sh >= (W + 2)'(den_reg)) begin
                    rem_next = rem_sh - (W + 2)'(den_reg);
                    q_next = {q_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next = {q_reg[W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                if (op_reg == nlsr_pkg::OP_SQRT) x_next = q_next;
                else mag_next = q_next;
            end
        end
        if (cmd.finish) begin
            rnd = (mag_reg >> (FB - 16)) + W'((mag_reg >> (FB - 17)) & W'(1));
            if (!neg_reg) out_next = (rnd > W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : rnd[31:0];
            else out_next = (rnd > W'(32'h80000000)) ? 32'h80000000 : 32'(0) - rnd[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            op_reg <= nlsr_pkg::OP_SQRT;
        end else begin
            busy_reg <= busy_next;
            op_reg <= op_next;
        end
        x_reg <= x_next; mag_reg <= mag_next; neg_reg <= neg_next;
        num_reg <= num_next; rem_reg <= rem_next; q_reg <= q_next;
        den_reg <= den_next; cnt_reg <= cnt_next; out_reg <= out_next;
    end

    assign log_value = out_reg;
endmodule

// ===== hdl/nlsr_ctrl.sv =====
// Controller state machine: sequences rounds and handles the result handshake.
module nlsr_ctrl #(
    parameter int MAX_ROUNDS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_operand,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output nlsr_pkg::dp_cmd_t  cmd,
    input  nlsr_pkg::dp_sts_t  sts
);
    localparam int RW = $clog2(MAX_ROUNDS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_SQRT  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_FIN   = 7'b0010000,
        S_SPEC  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [RW-1:0] round_reg, round_next;
    logic [1:0] status_reg, status_next;

    always_comb begin
        state_next = state_reg; round_next = round_reg; status_next = status_reg;
        cmd = '0;
        cmd.op = nlsr_pkg::OP_SQRT;
        s_ready = state_reg == S_IDLE;
        m_valid = state_reg == S_OUT;
        unique case (state_reg)
            S_IDLE: if (s_valid) begin
                round_next = '0;
                if (s_operand[31]) begin
                    status_next = nlsr_pkg::STATUS_DOMAIN; state_next = S_SPEC;
                end else if (s_operand == 32'd0) begin
                    status_next = nlsr_pkg::STATUS_RANGE; state_next = S_SPEC;
                end else begin
                    status_next = nlsr_pkg::STATUS_OK; cmd.load = 1'b1; state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.converged || round_reg == RW'(MAX_ROUNDS)) begin
                    cmd.finish = 1'b1; state_next = S_FIN;
                end else begin
                    cmd.start = 1'b1; cmd.op = nlsr_pkg::OP_SQRT; state_next = S_SQRT;
                end
            end
            S_SQRT: if (!sts.busy) begin
                cmd.start = 1'b1; cmd.op = nlsr_pkg::OP_DIV; state_next = S_DIV;
            end
            S_DIV: if (!sts.busy) begin
                round_next = round_reg + 1'b1; state_next = S_CHECK;
            end
            S_FIN: state_next = S_OUT;
            S_SPEC: state_next = S_OUT;
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            round_reg <= '0;
            status_reg <= nlsr_pkg::STATUS_OK;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            status_reg <= status_next;
        end
    end

    assign m_status = status_reg;
endmodule

// ===== hdl/nlsr_checker.sv =====
// Port-level checker for the logarithm unit and its bind.
`include "assert_macros.svh"
module nlsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_log_value,
    input logic [1:0]  m_status
);
    `ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_valid, !s_ready,
        "input taken while result pending")
    `ASSERT_IMPL(a_status_code, aclk, aresetn, m_valid,
        m_status <= nlsr_pkg::STATUS_DOMAIN, "bad status code")
    `ASSERT_IMPL(a_range_value, aclk, aresetn, m_valid && m_status == nlsr_pkg::STATUS_RANGE,
        m_log_value == 32'h80000000, "range value")
    `ASSERT_IMPL(a_domain_value, aclk, aresetn, m_valid && m_status == nlsr_pkg::STATUS_DOMAIN,
        m_log_value == 32'd0, "domain value")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_log_value), "result dropped")
endmodule

bind natural_log_by_square_roots_unit nlsr_checker u_nlsr_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_log_value, .m_status
);

// ===== dv/natural_log_by_square_roots_unit_tb.sv =====
// Testbench of the natural logarithm unit: directed and random operands checked against a predictor.
module natural_log_by_square_roots_unit_tb;
    localparam int MAX_ROUNDS = 64;
    localparam int FB = 32;
    // The watchdog limit sits well above the longest time that one word can take.
    localparam int STALL_LIMIT = 60000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [31:0] log_value;
        logic [1:0]  status;
    } log_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_operand = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_log_value;
    logic [1:0]  m_status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data = '0;

    // Predictor copy of the tolerance register.
    logic [16:0] tol_setting = 17'd1;
    log_word_t   expected_logs[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    bit          rx_hold = 1'b0;     // long receiver hold-off in progress
    bit          quiet_mode = 1'b0;  // no random idling on either side

    always #5 aclk = ~aclk;

    natural_log_by_square_roots_unit #(
        .MAX_ROUNDS(MAX_ROUNDS),
        .INTERNAL_FRACTION_BITS(FB)
    ) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operand(s_operand),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_log_value(m_log_value), .m_status(m_status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Exact digit-by-digit root of a 128-bit value.
    function automatic logic [63:0] isqrt128(input logic [127:0] v);
        logic [127:0] rem;
        logic [127:0] root;
        logic [127:0] trial;
        rem = '0;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
            trial = (root << 2) | 128'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 128'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[63:0];
    endfunction

    // Works out the logarithm word the block should return for one operand.
    function automatic log_word_t predict_log(input logic [31:0] operand);
        log_word_t w;
        logic [63:0] one;
        logic [63:0] x;
        logic [63:0] mag;
        logic [63:0] dev;
        logic [63:0] tol;
        logic [127:0] quot;
        bit neg;
        one = 64'd1 << FB;
        if (operand[31]) begin
            w.log_value = '0;
            w.status = nlsr_pkg::STATUS_DOMAIN;
        end else if (operand == '0) begin
            w.log_value = 32'h8000_0000;
            w.status = nlsr_pkg::STATUS_RANGE;
        end else begin
            x = 64'(operand) << (FB - 16);
            neg = x < one;
            mag = neg ? one - x : x - one;
            tol = 64'(tol_setting);
            for (int rnd = 0; rnd < MAX_ROUNDS; rnd++) begin
                dev = (x >= one) ? x - one : one - x;
                if (dev <= tol) break;
                x = isqrt128(128'(x) << FB);
                quot = (128'(mag) << (FB + 1)) / 128'(one + x);
                mag = quot[63:0];
            end
            // Round to Q16.16, ties away from zero on the magnitude.
            mag = (mag >> (FB - 16)) + ((mag >> (FB - 17)) & 64'd1);
            if (!neg && mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
            if (neg && mag > 64'h8000_0000) mag = 64'h8000_0000;
            w.log_value = neg ? 32'(64'd0 - mag) : mag[31:0];
            w.status = nlsr_pkg::STATUS_OK;
        end
        return w;
    endfunction

    // Sends one word and queues its expected logarithm once it is taken.
    // Valid stays high after acceptance until the next word or an idle cycle replaces it.
    task automatic send_operand(input logic [31:0] operand);
        while (!quiet_mode && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operand <= operand;
        do @(posedge aclk); while (!s_ready);
        expected_logs.push_back(predict_log(operand));
        @(negedge aclk);
    endtask

    // Drops valid and waits until every expected word is back, then idles before returning.
    task automatic drain;
        s_valid <= 1'b0;
        wait (expected_logs.size() == 0);
        repeat (20) @(negedge aclk);
    endtask

    // Writes the tolerance register while the block is idle.
    task automatic write_tolerance(input logic [16:0] value);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        tol_setting = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random positive operand: half small magnitudes, half full range.
    function automatic logic [31:0] random_positive();
        case ($urandom_range(3))
            0: return 32'($urandom_range(32'h0001_FFFF, 1));
            1: return 32'h0001_0000 + 32'($urandom_range(200)) - 32'd100;
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    task automatic test_special_cases;
        send_operand(32'h0000_0000);
        send_operand(32'h8000_0000);
        send_operand(32'hFFFF_FFFF);
        send_operand(32'h0001_0000);
        send_operand(32'h0000_0001);
        send_operand(32'h7FFF_FFFF);
        send_operand(32'h0000_FFFF);
        send_operand(32'h0001_0001);
        send_operand(32'h0002_0000);
        send_operand(32'h0002_B7E1);
        send_operand(32'h5555_5555);
        send_operand(32'h2AAA_AAAA);
    endtask

    task automatic test_tolerance_extremes;
        write_tolerance(17'd0);
        send_operand(32'h0003_0000);
        send_operand(32'h0000_8000);
        write_tolerance(17'h1_0000);
        send_operand(32'h0003_0000);
        send_operand(32'h7FFF_FFFF);
        write_tolerance(17'h1_FFFF);
        send_operand(32'h0000_0001);
        send_operand(32'h0001_0001);
        write_tolerance(17'd1);
    endtask

    task automatic test_random_operands(input int count);
        logic [31:0] op;
        for (int i = 0; i < count; i++) begin
            if (i % 70 == 69) write_tolerance(17'($urandom));
            if ($urandom_range(9) == 0) op = 32'($urandom);
            else op = random_positive();
            send_operand(op);
        end
    endtask

    // Receiver holds off while a burst of words is offered, so the input stalls.
    task automatic test_backpressure;
        drain();
        rx_hold = 1'b1;
        fork
            begin
                repeat (20000) @(negedge aclk);
                rx_hold = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_operand(32'($urandom_range(32'h0004_0000, 1)));
        join
    endtask

    task automatic test_quiet_stretch;
        quiet_mode = 1'b1;
        test_random_operands(30);
        drain();
        quiet_mode = 1'b0;
    endtask

    // Receiver ready: random idling, long holds, quiet stretches.
    always @(negedge aclk) begin
        m_ready <= !rx_hold && (quiet_mode || $urandom_range(99) >= 9);
    end

    // Compares each returned word with the oldest expectation.
    always @(posedge aclk) begin
        log_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_logs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected word: log_value=%h status=%0d", m_log_value, m_status);
            end else begin
                want = expected_logs.pop_front();
                if (want.log_value !== m_log_value || want.status !== m_status) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: expected log_value=%h status=%0d, got %h %0d",
                                 want.log_value, want.status, m_log_value, m_status);
                end
            end
        end
    end

    // Watchdog: counts cycles with no accepted word on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("** natural_log_by_square_roots_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        test_special_cases();
        test_tolerance_extremes();
        test_backpressure();
        test_quiet_stretch();
        test_random_operands(230);
        drain();
        if (mismatch_count == 0 && expected_logs.size() == 0)
            $display("** natural_log_by_square_roots_unit: PASSED **");
        else
            $display("** natural_log_by_square_roots_unit: FAILED **");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/nlsr_pkg.sv
hdl/nlsr_datapath.sv
hdl/nlsr_ctrl.sv
hdl/natural_log_by_square_roots_unit.sv
hdl/nlsr_checker.sv
dv/natural_log_by_square_roots_unit_tb.sv
